// ===== src/psq_pkg.sv =====
// Shared types, constants and codes of the priority quantum scheduler.
`default_nettype none

package psq_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned ARR_W    = 16;
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned TIME_W   = 21;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned QUANT_W  = 16;

  localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd4;

  localparam logic KIND_INSERT = 1'b0;

  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SLICE    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ALL_DONE = 2'd3;

  typedef enum logic {
    OP_INSERT,
    OP_SCHEDULE
  } op_e;

  typedef struct packed {
    logic               kind;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   slice_end;
    logic                finished;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
  } rsp_t;

  // classified request handed from the front queue to the engine
  typedef struct packed {
    op_e                op;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_t;

  // one process table entry as kept in the table RAM
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/psq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/psq_front.sv =====
// Front end: accepts requests, classifies them and queues them for the engine.
`default_nettype none

module psq_front
  import psq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      full_o,
  input  wire req_t req_i,
  output logic      job_vld_o,
  output job_t      job_o,
  input  wire logic job_rdy_i
);

  localparam int unsigned Depth = 2;

  job_t       buf_q [Depth];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       enq, deq;
  job_t       job_in;

  assign full_o    = (cnt_q == 2'(Depth));
  assign job_vld_o = (cnt_q != 2'd0);
  assign job_o     = buf_q[rd_q];

  assign enq = push_i && !full_o;
  assign deq = job_vld_o && job_rdy_i;

  always_comb begin
    job_in.op      = (req_i.kind == KIND_INSERT) ? OP_INSERT : OP_SCHEDULE;
    job_in.arrival = req_i.arrival;
    job_in.burst   = req_i.burst;
    job_in.prio    = req_i.priority_req;
  end

  always_comb begin
    wr_d  = enq ? ~wr_q : wr_q;
    rd_d  = deq ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 2'd1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      buf_q[wr_q] <= job_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/psq_engine.sv =====
// Back end: process table, selection scan, slice execution and result register.
`default_nettype none

module psq_engine
  import psq_pkg::*;
#(
  parameter int unsigned Slots = SLOTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 job_vld_i,
  input  wire job_t                 job_i,
  output logic                      job_rdy_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [QUANT_W-1:0]   cfg_wdata_i,
  output logic                      rsp_vld_o,
  output rsp_t                      rsp_o,
  input  wire logic                 rsp_pop_i
);

  localparam int unsigned SW = $clog2(Slots);
  localparam int unsigned CW = $clog2(Slots + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [TIME_W-1:0]    time_q, time_d;
  logic [QUANT_W-1:0]   quantum_q, quantum_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [SW-1:0]        rd_idx_q, rd_idx_d;
  // A: best among arrived entries; B: best among those at the earliest arrival
  logic                 a_vld_q, a_vld_d;
  entry_t               a_q, a_d;
  logic [SW-1:0]        a_idx_q, a_idx_d;
  logic                 b_vld_q, b_vld_d;
  entry_t               b_q, b_d;
  logic [SW-1:0]        b_idx_q, b_idx_d;
  logic                 none_q, none_d;
  entry_t               pick_q, pick_d;
  logic [SW-1:0]        pick_idx_q, pick_idx_d;
  logic [ARR_W:0]       ab_q, ab_d;
  logic                 rvld_q, rvld_d;
  rsp_t                 rslt_q, rslt_d;

  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;

  logic                 out_free;
  logic                 issue;
  entry_t               sel;
  logic [SW-1:0]        sel_idx;
  logic [TIME_W-1:0]    t_start;
  logic [QUANT_W-1:0]   run;
  logic [TIME_W:0]      t_sum;
  logic [TIME_W-1:0]    tat;
  logic [TIME_W-1:0]    ab_ext;
  logic [TIME_W-1:0]    rd_arr_ext;

  function automatic logic [SLOT_W-1:0] slot_of(logic [SW-1:0] idx);
    logic [SW+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, idx};
    return w[SLOT_W-1:0];
  endfunction

  // ordering key: priority, then remaining burst, then arrival
  function automatic logic key_lt(entry_t x, entry_t y);
    return {x.prio, x.remaining, x.arrival} < {y.prio, y.remaining, y.arrival};
  endfunction

  psq_ram #(
    .Width ($bits(entry_t)),
    .Depth (Slots)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q[SW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !rvld_q || rsp_pop_i;
  assign issue      = (scan_q < cnt_q);
  assign rd_arr_ext = {{(TIME_W-ARR_W){1'b0}}, ram_rdata.arrival};
  assign ab_ext     = {{(TIME_W-ARR_W-1){1'b0}}, ab_q};
  assign tat        = time_q - {{(TIME_W-ARR_W){1'b0}}, pick_q.arrival};

  always_comb begin
    sel     = a_vld_q ? a_q : b_q;
    sel_idx = a_vld_q ? a_idx_q : b_idx_q;
    // nothing arrived yet: time jumps to the earliest arrival
    t_start = a_vld_q ? time_q : {{(TIME_W-ARR_W){1'b0}}, b_q.arrival};
    run     = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
    if (run > sel.remaining) begin
      run = sel.remaining;
    end
    t_sum = {1'b0, t_start} + {{(TIME_W+1-QUANT_W){1'b0}}, run};
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    time_d     = time_q;
    quantum_d  = cfg_we_i ? cfg_wdata_i : quantum_q;
    scan_d     = scan_q;
    rd_vld_d   = rd_vld_q;
    rd_idx_d   = rd_idx_q;
    a_vld_d    = a_vld_q;
    a_d        = a_q;
    a_idx_d    = a_idx_q;
    b_vld_d    = b_vld_q;
    b_d        = b_q;
    b_idx_d    = b_idx_q;
    none_d     = none_q;
    pick_d     = pick_q;
    pick_idx_d = pick_idx_q;
    ab_d       = ab_q;
    rvld_d     = rvld_q;
    rslt_d     = rslt_q;
    job_rdy_o  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pick_idx_q;
    ram_wdata  = pick_q;

    if (rvld_q && rsp_pop_i) begin
      rvld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (job_vld_i && out_free) begin
          job_rdy_o = 1'b1;
          if (job_i.op == OP_INSERT) begin
            rvld_d = 1'b1;
            rslt_d = '0;
            if (cnt_q >= CW'(Slots)) begin
              rslt_d.status = STAT_FULL;
            end else begin
              ram_we              = 1'b1;
              ram_waddr           = cnt_q[SW-1:0];
              ram_wdata.arrival   = job_i.arrival;
              ram_wdata.burst     = job_i.burst;
              ram_wdata.remaining = job_i.burst;
              ram_wdata.prio      = job_i.prio;
              rslt_d.status       = STAT_INSERTED;
              rslt_d.slot         = slot_of(cnt_q[SW-1:0]);
              cnt_d               = cnt_q + CW'(1);
            end
          end else begin
            scan_d   = '0;
            rd_vld_d = 1'b0;
            a_vld_d  = 1'b0;
            b_vld_d  = 1'b0;
            state_d  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        rd_vld_d = issue;
        rd_idx_d = scan_q[SW-1:0];
        if (issue) begin
          scan_d = scan_q + CW'(1);
        end
        // slots come in ascending order, so a strict compare keeps the lower slot
        if (rd_vld_q && ram_rdata.remaining != '0) begin
          if (rd_arr_ext <= time_q && (!a_vld_q || key_lt(ram_rdata, a_q))) begin
            a_vld_d = 1'b1;
            a_d     = ram_rdata;
            a_idx_d = rd_idx_q;
          end
          if (!b_vld_q || ram_rdata.arrival < b_q.arrival ||
              (ram_rdata.arrival == b_q.arrival && key_lt(ram_rdata, b_q))) begin
            b_vld_d = 1'b1;
            b_d     = ram_rdata;
            b_idx_d = rd_idx_q;
          end
        end
        if (!issue && !rd_vld_q) begin
          none_d  = !b_vld_q;
          state_d = b_vld_q ? ST_EXEC : ST_FIN;
        end
      end

      ST_EXEC: begin
        pick_d           = sel;
        pick_d.remaining = sel.remaining - run;
        pick_idx_d       = sel_idx;
        ab_d             = {1'b0, sel.arrival} + {1'b0, sel.burst};
        time_d           = t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
        ram_we           = 1'b1;
        ram_waddr        = sel_idx;
        ram_wdata        = sel;
        ram_wdata.remaining = sel.remaining - run;
        state_d          = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          rvld_d           = 1'b1;
          rslt_d           = '0;
          rslt_d.slice_end = time_q;
          if (none_q) begin
            rslt_d.status = STAT_ALL_DONE;
          end else begin
            rslt_d.status = STAT_SLICE;
            rslt_d.slot   = slot_of(pick_idx_q);
            if (pick_q.remaining == '0) begin
              rslt_d.finished   = 1'b1;
              rslt_d.turnaround = tat;
              rslt_d.waiting    = (time_q > ab_ext) ? (time_q - ab_ext) : '0;
            end
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      time_q     <= '0;
      quantum_q  <= QUANTUM_RST;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      a_vld_q    <= 1'b0;
      a_q        <= '0;
      a_idx_q    <= '0;
      b_vld_q    <= 1'b0;
      b_q        <= '0;
      b_idx_q    <= '0;
      none_q     <= 1'b0;
      pick_q     <= '0;
      pick_idx_q <= '0;
      ab_q       <= '0;
      rvld_q     <= 1'b0;
      rslt_q     <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      time_q     <= time_d;
      quantum_q  <= quantum_d;
      scan_q     <= scan_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      a_vld_q    <= a_vld_d;
      a_q        <= a_d;
      a_idx_q    <= a_idx_d;
      b_vld_q    <= b_vld_d;
      b_q        <= b_d;
      b_idx_q    <= b_idx_d;
      none_q     <= none_d;
      pick_q     <= pick_d;
      pick_idx_q <= pick_idx_d;
      ab_q       <= ab_d;
      rvld_q     <= rvld_d;
      rslt_q     <= rslt_d;
    end
  end

  assign rsp_vld_o = rvld_q;
  assign rsp_o     = rslt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Slots))
    else $error("entry count beyond table size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> scan_q <= cnt_q)
    else $error("scan index past entry count");

  a_exec_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> b_vld_q)
    else $error("slice run without a candidate");

  a_arrived_implies_earliest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> b_vld_q)
    else $error("arrived candidate without earliest-arrival candidate");
`endif

endmodule

`default_nettype wire

// ===== src/preemptive_priority_quantum_scheduler.sv =====
// An insert request is answered in the cycle after acceptance; inserts run one per cycle while
// each result is popped. A schedule request scans the table, one RAM read per entry, then runs
// a slice of the selected entry and writes its result; the slice run is skipped when no entry is
// left to run. One request is worked on at a time; an unpopped result stalls the engine.
// Reset clears the entry count, the time and the queues, and sets quantum to 4.
// Top level of the preemptive priority scheduler with time quantum.
`default_nettype none

module preemptive_priority_quantum_scheduler
  import psq_pkg::*;
#(
  parameter int unsigned Slots = SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire req_t               req_i,
  output logic                    empty,
  input  wire logic               pop,
  output rsp_t                    rsp_o,
  input  wire logic               cfg_we_i,
  input  wire logic [QUANT_W-1:0] cfg_wdata_i
);

  logic job_vld;
  logic job_rdy;
  job_t job;
  logic rsp_vld;

  psq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .req_i     (req_i),
    .job_vld_o (job_vld),
    .job_o     (job),
    .job_rdy_i (job_rdy)
  );

  psq_engine #(
    .Slots (Slots)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_vld_i   (job_vld),
    .job_i       (job),
    .job_rdy_o   (job_rdy),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_vld_o   (rsp_vld),
    .rsp_o       (rsp_o),
    .rsp_pop_i   (pop)
  );

  assign empty = !rsp_vld;

endmodule

`default_nettype wire
